// ----- hdl/ise_pkg.sv -----
package ise_pkg;

   // input coordinate and bound
   localparam int CoordW = 23;
   localparam logic [CoordW-1:0] CoordBound = 23'd8000000;

   // control row widths
   localparam int XW  = CoordW + 2;          // 2*coord, signed
   localparam int QW  = 2 * CoordW;          // coord*coord, unsigned
   localparam int ZW  = QW + 3;              // 2*(qx+qy), signed
   localparam int DXW = XW + 1;              // row difference x/y
   localparam int DZW = ZW + 1;              // row difference z
   localparam int PXW = 2 * DXW;             // x*y product
   localparam int MW  = PXW + 1;             // 2x2 minor
   localparam int ZMW = DZW - 1;             // |dz|
   localparam int MMW = MW - 1;              // |minor|
   localparam int ZLW = (ZMW + 1) / 2;       // low part of |dz|
   localparam int ZHW = ZMW - ZLW;
   localparam int MLW = (MMW + 1) / 2;       // low part of |minor|
   localparam int MHW = MMW - MLW;
   localparam int PW  = ZMW + MMW;           // product magnitude
   localparam int SW  = PW + 3;              // signed sum of three

   localparam int DetStages = 10;

   // enumeration of the 9^4 row combinations: eight base-3 digits
   localparam int NumBoxes  = 4;
   localparam int NumDigits = 2 * NumBoxes;
   localparam logic [1:0] DigitMax = 2'd2;
   localparam logic [2:0] ProdLast = 3'd5;

   // sign mask codes
   localparam logic [2:0] MaskNone  = 3'b000;
   localparam logic [2:0] MaskNeg   = 3'b001;
   localparam logic [2:0] MaskZero  = 3'b010;
   localparam logic [2:0] MaskPos   = 3'b100;
   localparam logic [2:0] MaskBoth  = 3'b101;
   localparam logic [2:0] MaskEarly = 3'b111;

   localparam logic [1:0] SlotLast = 2'd3;

   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] bottom;
      logic [CoordW-1:0] right;
      logic [CoordW-1:0] top;
   } box_type;

   typedef struct packed {
      box_type [NumBoxes-1:0] box;
      logic                   err;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } row_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SETUP,
      BK_SWEEP,
      BK_DRAIN
   } back_state_type;

endpackage

// ----- hdl/ise_front.sv -----
module ise_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [1:0]                   slot,
   input  logic [ise_pkg::CoordW-1:0]   left,
   input  logic [ise_pkg::CoordW-1:0]   bottom,
   input  logic [ise_pkg::CoordW-1:0]   right,
   input  logic [ise_pkg::CoordW-1:0]   top,
   output logic                         push,
   output ise_pkg::job_type             job
);

   ise_pkg::box_type store_ff [ise_pkg::NumBoxes];
   ise_pkg::box_type box_in;
   logic             group_error_ff;
   logic             group_error_in;
   logic             bad;

   // classify the incoming box
   always_comb begin
      box_in = '{left: left, bottom: bottom, right: right, top: top};
      bad = (right < left) || (top < bottom) ||
            (right > ise_pkg::CoordBound) || (top > ise_pkg::CoordBound);
      push = accept && (slot == ise_pkg::SlotLast);
      for (int n = 0; n < ise_pkg::NumBoxes; n++) begin
         job.box[n] = store_ff[n];
      end
      job.box[ise_pkg::SlotLast] = box_in;
      job.err = group_error_ff || bad;
      group_error_in = group_error_ff;
      if (accept) begin
         group_error_in = push ? 1'b0 : (group_error_ff || bad);
      end
   end

   // store the box in its slot
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[slot] <= box_in;
      end
   end

   // hold the sticky group error
   always_ff @(posedge clock) begin
      if (reset) begin
         group_error_ff <= 1'b0;
      end else begin
         group_error_ff <= group_error_in;
      end
   end

endmodule

// ----- hdl/ise_fifo.sv -----
module ise_fifo #(
   parameter int Depth = ise_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ise_pkg::job_type        push_job,
   input  logic                    pop,
   output ise_pkg::job_type        head_job,
   output ise_pkg::queue_stat_type stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   ise_pkg::job_type entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == CntFull);
      head_job   = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/ise_det.sv -----
module ise_det (
   input  logic             clock,
   input  logic             reset,
   input  logic             flush,
   input  logic             in_valid,
   input  ise_pkg::row_type row_a,
   input  ise_pkg::row_type row_b,
   input  ise_pkg::row_type row_c,
   input  ise_pkg::row_type row_d,
   output logic             out_valid,
   output logic [2:0]       out_code,
   output logic             active
);

   localparam int DXW = ise_pkg::DXW;
   localparam int DZW = ise_pkg::DZW;
   localparam int PXW = ise_pkg::PXW;
   localparam int MW  = ise_pkg::MW;
   localparam int ZMW = ise_pkg::ZMW;
   localparam int MMW = ise_pkg::MMW;
   localparam int ZLW = ise_pkg::ZLW;
   localparam int ZHW = ise_pkg::ZHW;
   localparam int MLW = ise_pkg::MLW;
   localparam int MHW = ise_pkg::MHW;
   localparam int PW  = ise_pkg::PW;
   localparam int SW  = ise_pkg::SW;

   logic [ise_pkg::DetStages-1:0] vld_ff;

   logic signed [DXW-1:0] dx_ff [3];
   logic signed [DXW-1:0] dy_ff [3];
   logic signed [DZW-1:0] dz1_ff [3];
   logic signed [PXW-1:0] pa_ff [3];
   logic signed [PXW-1:0] pb_ff [3];
   logic signed [DZW-1:0] dz2_ff [3];
   logic signed [MW-1:0]  m_ff [3];
   logic signed [DZW-1:0] dz3_ff [3];
   logic [ZMW-1:0]        zmag_ff [3];
   logic [MMW-1:0]        mmag_ff [3];
   logic                  neg4_ff [3];
   logic [ZHW+MHW-1:0]    hh_ff [3];
   logic [ZHW+MLW-1:0]    hl_ff [3];
   logic [ZLW+MHW-1:0]    lh_ff [3];
   logic [ZLW+MLW-1:0]    ll_ff [3];
   logic                  neg5_ff [3];
   logic [PW-1:0]         t1_ff [3];
   logic [PW-1:0]         t2_ff [3];
   logic                  neg6_ff [3];
   logic [PW-1:0]         mag_ff [3];
   logic                  neg7_ff [3];
   logic signed [SW-1:0]  sv_ff [3];
   logic signed [SW-1:0]  sum_ff;
   logic [2:0]            code_ff;

   logic signed [DZW-1:0] zneg [3];
   logic signed [MW-1:0]  mneg [3];

   // track valid items, drop all on flush
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ise_pkg::DetStages-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[ise_pkg::DetStages-1];
   assign out_code  = code_ff;
   assign active    = |vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         zneg[k] = -dz3_ff[k];
         mneg[k] = -m_ff[k];
      end
   end

   // datapath: differences, minors, split products, sum, sign
   always_ff @(posedge clock) begin
      dx_ff[0]  <= DXW'(row_b.x) - DXW'(row_a.x);
      dx_ff[1]  <= DXW'(row_c.x) - DXW'(row_a.x);
      dx_ff[2]  <= DXW'(row_d.x) - DXW'(row_a.x);
      dy_ff[0]  <= DXW'(row_b.y) - DXW'(row_a.y);
      dy_ff[1]  <= DXW'(row_c.y) - DXW'(row_a.y);
      dy_ff[2]  <= DXW'(row_d.y) - DXW'(row_a.y);
      dz1_ff[0] <= DZW'(row_b.z) - DZW'(row_a.z);
      dz1_ff[1] <= DZW'(row_c.z) - DZW'(row_a.z);
      dz1_ff[2] <= DZW'(row_d.z) - DZW'(row_a.z);

      pa_ff[0] <= PXW'(dx_ff[1]) * PXW'(dy_ff[2]);
      pb_ff[0] <= PXW'(dx_ff[2]) * PXW'(dy_ff[1]);
      pa_ff[1] <= PXW'(dx_ff[0]) * PXW'(dy_ff[2]);
      pb_ff[1] <= PXW'(dx_ff[2]) * PXW'(dy_ff[0]);
      pa_ff[2] <= PXW'(dx_ff[0]) * PXW'(dy_ff[1]);
      pb_ff[2] <= PXW'(dx_ff[1]) * PXW'(dy_ff[0]);

      for (int k = 0; k < 3; k++) begin
         dz2_ff[k] <= dz1_ff[k];
         m_ff[k]   <= MW'(pa_ff[k]) - MW'(pb_ff[k]);
         dz3_ff[k] <= dz2_ff[k];

         zmag_ff[k] <= dz3_ff[k][DZW-1] ? zneg[k][ZMW-1:0] : dz3_ff[k][ZMW-1:0];
         mmag_ff[k] <= m_ff[k][MW-1] ? mneg[k][MMW-1:0] : m_ff[k][MMW-1:0];
         // middle term enters with a minus sign
         neg4_ff[k] <= dz3_ff[k][DZW-1] ^ m_ff[k][MW-1] ^ (k == 1);

         hh_ff[k]   <= (ZHW+MHW)'(zmag_ff[k][ZMW-1:ZLW]) * (ZHW+MHW)'(mmag_ff[k][MMW-1:MLW]);
         hl_ff[k]   <= (ZHW+MLW)'(zmag_ff[k][ZMW-1:ZLW]) * (ZHW+MLW)'(mmag_ff[k][MLW-1:0]);
         lh_ff[k]   <= (ZLW+MHW)'(zmag_ff[k][ZLW-1:0]) * (ZLW+MHW)'(mmag_ff[k][MMW-1:MLW]);
         ll_ff[k]   <= (ZLW+MLW)'(zmag_ff[k][ZLW-1:0]) * (ZLW+MLW)'(mmag_ff[k][MLW-1:0]);
         neg5_ff[k] <= neg4_ff[k];

         t1_ff[k]   <= {hh_ff[k], ll_ff[k]};
         t2_ff[k]   <= (PW'(hl_ff[k]) << ZLW) + (PW'(lh_ff[k]) << MLW);
         neg6_ff[k] <= neg5_ff[k];

         mag_ff[k]  <= t1_ff[k] + t2_ff[k];
         neg7_ff[k] <= neg6_ff[k];

         sv_ff[k] <= neg7_ff[k] ? -$signed(SW'(mag_ff[k])) : $signed(SW'(mag_ff[k]));
      end

      sum_ff <= sv_ff[0] + sv_ff[1] + sv_ff[2];

      // negative sub-determinant means a positive lifted determinant
      if (sum_ff == '0) begin
         code_ff <= ise_pkg::MaskZero;
      end else if (sum_ff[SW-1]) begin
         code_ff <= ise_pkg::MaskPos;
      end else begin
         code_ff <= ise_pkg::MaskNeg;
      end
   end

endmodule

// ----- hdl/ise_back.sv -----
module ise_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ise_pkg::queue_stat_type qstat,
   input  ise_pkg::job_type        head_job,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_sign_mask,
   output logic                    rsp_box_error
);

   localparam int NB = ise_pkg::NumBoxes;
   localparam int ND = ise_pkg::NumDigits;
   localparam int CW = ise_pkg::CoordW;
   localparam int QW = ise_pkg::QW;

   ise_pkg::back_state_type state_ff, state_in;
   ise_pkg::job_type        job_ff;
   ise_pkg::box_type        sel_box;
   logic [QW-1:0]           qx_ff [NB][3];
   logic [QW-1:0]           qy_ff [NB][3];
   logic [1:0]              box_idx_ff;
   logic [2:0]              prod_idx_ff;
   logic [CW-1:0]           op_a, op_b;
   logic [QW-1:0]           prod;
   logic [1:0]              dig_ff [ND];
   logic [1:0]              dig_in [ND];
   logic                    carry [ND+1];
   logic                    last_combo;
   ise_pkg::row_type        row_ff [NB];
   ise_pkg::row_type        row_in [NB];
   logic                    row_vld_ff;
   logic [2:0]              mask_ff, mask_in;
   logic                    det_valid, det_active;
   logic [2:0]              det_code;
   logic                    early;
   logic                    flush;
   logic                    load, emit, emit_err;
   logic [2:0]              emit_mask;
   logic                    rsp_valid_ff;
   logic [2:0]              rsp_mask_ff;
   logic                    rsp_err_ff;

   // one shared multiplier for the per-box squares and cross products
   always_comb begin
      sel_box = job_ff.box[box_idx_ff];
      case (prod_idx_ff)
         3'd0:    begin op_a = sel_box.left;   op_b = sel_box.left;   end
         3'd1:    begin op_a = sel_box.left;   op_b = sel_box.right;  end
         3'd2:    begin op_a = sel_box.right;  op_b = sel_box.right;  end
         3'd3:    begin op_a = sel_box.bottom; op_b = sel_box.bottom; end
         3'd4:    begin op_a = sel_box.bottom; op_b = sel_box.top;    end
         default: begin op_a = sel_box.top;    op_b = sel_box.top;    end
      endcase
      prod = QW'(op_a) * QW'(op_b);
   end

   // step the base-3 digit counter, last box fastest
   always_comb begin
      carry[ND] = 1'b1;
      for (int d = ND - 1; d >= 0; d--) begin
         if (carry[d+1]) begin
            dig_in[d] = (dig_ff[d] == ise_pkg::DigitMax) ? 2'd0 : dig_ff[d] + 2'd1;
            carry[d]  = (dig_ff[d] == ise_pkg::DigitMax);
         end else begin
            dig_in[d] = dig_ff[d];
            carry[d]  = 1'b0;
         end
      end
      last_combo = carry[0];
   end

   // build the four control rows for the current combination
   always_comb begin
      for (int n = 0; n < NB; n++) begin
         case (dig_ff[2*n])
            2'd0:    row_in[n].x = ise_pkg::XW'({job_ff.box[n].left, 1'b0});
            2'd1:    row_in[n].x = ise_pkg::XW'(job_ff.box[n].left) +
                                   ise_pkg::XW'(job_ff.box[n].right);
            default: row_in[n].x = ise_pkg::XW'({job_ff.box[n].right, 1'b0});
         endcase
         case (dig_ff[2*n+1])
            2'd0:    row_in[n].y = ise_pkg::XW'({job_ff.box[n].bottom, 1'b0});
            2'd1:    row_in[n].y = ise_pkg::XW'(job_ff.box[n].bottom) +
                                   ise_pkg::XW'(job_ff.box[n].top);
            default: row_in[n].y = ise_pkg::XW'({job_ff.box[n].top, 1'b0});
         endcase
         row_in[n].z = (ise_pkg::ZW'(qx_ff[n][dig_ff[2*n]]) +
                        ise_pkg::ZW'(qy_ff[n][dig_ff[2*n+1]])) <<< 1;
      end
   end

   ise_det u_det (
      .clock     (clock),
      .reset     (reset),
      .flush     (flush),
      .in_valid  (row_vld_ff),
      .row_a     (row_ff[0]),
      .row_b     (row_ff[1]),
      .row_c     (row_ff[2]),
      .row_d     (row_ff[3]),
      .out_valid (det_valid),
      .out_code  (det_code),
      .active    (det_active)
   );

   // next state and control
   always_comb begin
      state_in  = state_ff;
      mask_in   = mask_ff | (det_valid ? det_code : ise_pkg::MaskNone);
      early     = ((mask_in & ise_pkg::MaskBoth) == ise_pkg::MaskBoth);
      pop       = 1'b0;
      load      = 1'b0;
      flush     = 1'b0;
      emit      = 1'b0;
      emit_err  = 1'b0;
      emit_mask = ise_pkg::MaskNone;
      unique case (state_ff)
         ise_pkg::BK_IDLE: begin
            mask_in = ise_pkg::MaskNone;
            if (!qstat.empty) begin
               pop  = 1'b1;
               load = 1'b1;
               if (head_job.err) begin
                  emit     = 1'b1;
                  emit_err = 1'b1;
               end else begin
                  state_in = ise_pkg::BK_SETUP;
               end
            end
         end
         ise_pkg::BK_SETUP: begin
            if (box_idx_ff == 2'(NB - 1) && prod_idx_ff == ise_pkg::ProdLast) begin
               state_in = ise_pkg::BK_SWEEP;
            end
         end
         ise_pkg::BK_SWEEP: begin
            if (early) begin
               emit      = 1'b1;
               emit_mask = ise_pkg::MaskEarly;
               flush     = 1'b1;
               state_in  = ise_pkg::BK_IDLE;
            end else if (last_combo) begin
               state_in = ise_pkg::BK_DRAIN;
            end
         end
         ise_pkg::BK_DRAIN: begin
            if (early) begin
               emit      = 1'b1;
               emit_mask = ise_pkg::MaskEarly;
               flush     = 1'b1;
               state_in  = ise_pkg::BK_IDLE;
            end else if (!row_vld_ff && !det_active) begin
               emit      = 1'b1;
               emit_mask = mask_ff;
               state_in  = ise_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ise_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ise_pkg::BK_IDLE;
         row_vld_ff   <= 1'b0;
         mask_ff      <= ise_pkg::MaskNone;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_vld_ff   <= (state_ff == ise_pkg::BK_SWEEP) && !flush;
         mask_ff      <= mask_in;
         rsp_valid_ff <= emit;
      end
   end

   // payload: job, tables, counters, rows and result
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= head_job;
      end
      if (state_ff == ise_pkg::BK_IDLE) begin
         box_idx_ff  <= '0;
         prod_idx_ff <= '0;
         for (int d = 0; d < ND; d++) begin
            dig_ff[d] <= 2'd0;
         end
      end else if (state_ff == ise_pkg::BK_SETUP) begin
         if (prod_idx_ff < 3'd3) begin
            qx_ff[box_idx_ff][prod_idx_ff[1:0]] <= prod;
         end else begin
            qy_ff[box_idx_ff][2'(prod_idx_ff - 3'd3)] <= prod;
         end
         if (prod_idx_ff == ise_pkg::ProdLast) begin
            prod_idx_ff <= '0;
            box_idx_ff  <= box_idx_ff + 2'd1;
         end else begin
            prod_idx_ff <= prod_idx_ff + 3'd1;
         end
      end else if (state_ff == ise_pkg::BK_SWEEP) begin
         for (int d = 0; d < ND; d++) begin
            dig_ff[d] <= dig_in[d];
         end
      end
      for (int n = 0; n < NB; n++) begin
         row_ff[n] <= row_in[n];
      end
      if (emit) begin
         rsp_mask_ff <= emit_mask;
         rsp_err_ff  <= emit_err;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sign_mask = rsp_mask_ff;
   assign rsp_box_error = rsp_err_ff;

endmodule

// ----- hdl/incircle_sign_enclosure_core.sv -----
// Slots 0..2 are only stored; a slot-3 transfer with a box error gives its result
// without evaluation, otherwise after the shared multiplier has set up the squares
// and cross products, a sweep of up to 6561 row combinations at one per cycle and
// the drain of the determinant pipeline.
// The job queue lets the front take items until it is full; busy then stays high.
// Reset: synchronous, clears all control state; the receiver cannot stall.
module incircle_sign_enclosure_core #(
   parameter int QueueDepth = ise_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_slot,
   input  logic [ise_pkg::CoordW-1:0] req_left,
   input  logic [ise_pkg::CoordW-1:0] req_bottom,
   input  logic [ise_pkg::CoordW-1:0] req_right,
   input  logic [ise_pkg::CoordW-1:0] req_top,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_sign_mask,
   output logic                       rsp_box_error
);

   ise_pkg::job_type        push_job;
   ise_pkg::job_type        head_job;
   ise_pkg::queue_stat_type qstat;
   logic                    accept;
   logic                    push;
   logic                    pop;

   // accept a transfer while the queue has room
   assign busy   = qstat.full;
   assign accept = start && !busy;

   ise_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .slot   (req_slot),
      .left   (req_left),
      .bottom (req_bottom),
      .right  (req_right),
      .top    (req_top),
      .push   (push),
      .job    (push_job)
   );

   ise_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (qstat)
   );

   ise_back u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (qstat),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_sign_mask (rsp_sign_mask),
      .rsp_box_error (rsp_box_error)
   );

   // error results carry an empty mask
   a_err_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_box_error |-> rsp_sign_mask == ise_pkg::MaskNone)
      else $error("error result with nonzero mask");

   // an evaluated group reports at least one sign
   a_eval_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_box_error |-> rsp_sign_mask != ise_pkg::MaskNone)
      else $error("evaluated result with empty mask");

   // both signs seen always reports as early exit
   a_both_early: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_sign_mask & ise_pkg::MaskBoth) == ise_pkg::MaskBoth)
      |-> rsp_sign_mask == ise_pkg::MaskEarly)
      else $error("both signs without early mask");

   // the queue is not full and no result is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or result after reset");

endmodule
